// File: design/srctok_pkg.sv
// ----------------------------------------------------------------------------
// srctok_pkg
// Shared types and constants of the assembler source tokenizer.
// ----------------------------------------------------------------------------
package srctok_pkg;

	localparam int MAX_LINE = 80;

	localparam logic [6:0]  LIMIT_CAP       = 7'(MAX_LINE - 1);
	localparam logic [6:0]  LINE_LIMIT_RST  = 7'd79;
	localparam logic [14:0] MAX_LINES_RST   = 15'd32767;
	localparam logic [14:0] LINE_NUMBER_RST = 15'd1;
	localparam logic [7:0]  CHECKSUM_INIT   = 8'hFF;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;

	typedef enum logic [0:0] {
		REG_LINE_LIMIT = 1'b0,
		REG_MAX_LINES  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic        line_closed;
		logic [7:0]  running_checksum;
		logic [15:0] emitted_count;
		logic        text_full;
	} out_beat_t;

	typedef struct packed {
		logic [6:0]  line_limit;
		logic [14:0] max_lines;
	} cfg_t;

	// Up to four bytes caused by one input beat; a close is always the last one.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            closes;
		logic            full;
	} bundle_t;

endpackage

// File: design/srctok_cfg.sv
// ----------------------------------------------------------------------------
// srctok_cfg
// Configuration registers: line length limit and maximum line count.
// ----------------------------------------------------------------------------
module srctok_cfg
	import srctok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	output cfg_t        cfg
);

	logic [6:0]  line_limit_q;
	logic [14:0] max_lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LINE_LIMIT_RST;
			max_lines_q  <= MAX_LINES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_LIMIT: line_limit_q <= cfg_wdata[6:0];
				REG_MAX_LINES:  max_lines_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.line_limit = line_limit_q;
	assign cfg.max_lines  = max_lines_q;

endmodule

// File: design/srctok_eval.sv
// ----------------------------------------------------------------------------
// srctok_eval
// Input register and line state; turns one text beat into a result bundle.
// ----------------------------------------------------------------------------
module srctok_eval
	import srctok_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_beat_t in_data,
	output logic     push,
	input  logic     push_ready,
	output bundle_t  bundle
);

	logic        valid_s1;
	in_beat_t    item_s1;

	logic [14:0] line_number_q;
	logic [6:0]  chars_q;
	logic        line_open_q;
	logic        quotes_q;
	logic        comment_q;
	logic        blank_q;
	logic        stopped_q;

	logic [6:0]  chars_base;
	logic [6:0]  chars_next;
	logic [6:0]  limit;
	logic        quotes_base;
	logic        comment_base;
	logic        blank_base;
	logic        quotes_next;
	logic        comment_next;
	logic        blank_next;
	logic        is_lf;
	logic        is_blank;
	logic        emit_char;
	logic [7:0]  char_out;
	logic        close;
	logic        stop_now;
	logic [2:0]  n;
	logic [3:0][7:0] bytes;
	logic        advance;

	always_comb begin
		chars_base   = line_open_q ? chars_q : 7'd0;
		quotes_base  = line_open_q & quotes_q;
		comment_base = line_open_q & comment_q;
		blank_base   = line_open_q & blank_q;
		is_lf        = item_s1.text_byte == CHAR_LF;
		is_blank     = (item_s1.text_byte == CHAR_SPACE) || (item_s1.text_byte == CHAR_TAB);
		limit        = (cfg.line_limit > LIMIT_CAP) ? LIMIT_CAP : cfg.line_limit;

		chars_next   = chars_base;
		quotes_next  = quotes_base;
		comment_next = comment_base;
		blank_next   = blank_base;
		emit_char    = 1'b0;
		char_out     = item_s1.text_byte;

		if (!is_lf) begin
			chars_next = chars_base + 7'd1;
			if (!comment_base) begin
				if (is_blank && !quotes_base) begin
					emit_char  = !blank_base;
					char_out   = CHAR_TAB;
					blank_next = 1'b1;
				end else begin
					blank_next = 1'b0;
					if (item_s1.text_byte == CHAR_SEMI && !quotes_base) begin
						comment_next = 1'b1;
					end else begin
						if (item_s1.text_byte == CHAR_QUOTE) begin
							quotes_next = !quotes_base;
						end
						emit_char = 1'b1;
					end
				end
			end
		end

		close    = is_lf || (chars_next >= limit) || item_s1.end_of_text;
		stop_now = close && (line_number_q >= cfg.max_lines);

		bytes = '0;
		n     = 3'd0;
		if (!line_open_q) begin
			bytes[0] = line_number_q[7:0];
			bytes[1] = {1'b0, line_number_q[14:8]};
			n        = 3'd2;
		end
		if (emit_char) begin
			bytes[n[1:0]] = char_out;
			n             = n + 3'd1;
		end
		if (close) begin
			bytes[n[1:0]] = CHAR_CR;
			n             = n + 3'd1;
		end
		if (stopped_q) begin
			n = 3'd0;
		end
	end

	assign bundle.bytes  = bytes;
	assign bundle.count  = n;
	assign bundle.closes = close;
	assign bundle.full   = stop_now;

	assign advance  = valid_s1 && ((n == 3'd0) || push_ready);
	assign push     = valid_s1 && (n != 3'd0) && push_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_number_q <= LINE_NUMBER_RST;
			chars_q       <= 7'd0;
			line_open_q   <= 1'b0;
			quotes_q      <= 1'b0;
			comment_q     <= 1'b0;
			blank_q       <= 1'b0;
			stopped_q     <= 1'b0;
		end else if (advance && !stopped_q) begin
			chars_q     <= chars_next;
			quotes_q    <= quotes_next;
			comment_q   <= comment_next;
			blank_q     <= blank_next;
			line_open_q <= !close;
			if (stop_now) begin
				stopped_q <= 1'b1;
			end else if (close) begin
				line_number_q <= line_number_q + 15'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_stopped_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared");
	a_no_push_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !push)
		else $error("bundle pushed while stopped");
`endif

endmodule

// File: design/srctok_emit.sv
// ----------------------------------------------------------------------------
// srctok_emit
// Bundle register that sends its bytes one beat at a time with checksum and count.
// ----------------------------------------------------------------------------
module srctok_emit
	import srctok_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      push_ready,
	input  bundle_t   bundle,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	logic        valid_s2;
	bundle_t     bundle_s2;
	logic [1:0]  idx_q;
	logic [7:0]  xor_q;
	logic [15:0] total_q;
	logic        is_last;
	logic        beat;
	logic [7:0]  cur_byte;

	assign cur_byte   = bundle_s2.bytes[idx_q];
	assign is_last    = {1'b0, idx_q} == (bundle_s2.count - 3'd1);
	assign beat       = valid_s2 && out_ready;
	assign push_ready = !valid_s2 || (out_ready && is_last);
	assign out_valid  = valid_s2;

	assign out_data.out_byte         = cur_byte;
	assign out_data.last_of_run      = is_last;
	assign out_data.line_closed      = is_last && bundle_s2.closes;
	assign out_data.running_checksum = xor_q ^ cur_byte;
	assign out_data.emitted_count    = total_q + 16'd1;
	assign out_data.text_full        = is_last && bundle_s2.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
			xor_q    <= CHECKSUM_INIT;
			total_q  <= 16'd0;
		end else begin
			if (beat) begin
				xor_q   <= xor_q ^ cur_byte;
				total_q <= total_q + 16'd1;
			end
			if (push_ready) begin
				valid_s2 <= push;
				idx_q    <= 2'd0;
			end else if (beat) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push) begin
			bundle_s2 <= bundle;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (bundle_s2.count != 3'd0) && (bundle_s2.count <= 3'd4))
		else $error("bundle held with bad byte count");
	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		beat |=> total_q == $past(total_q) + 16'd1)
		else $error("emitted count did not advance on a beat");
`endif

endmodule

// File: design/assembler_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// assembler_source_tokenizer_top
// Converts a text byte stream into the numbered assembler source stream.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (in_beat_t)
//   out      output     out_valid / out_ready  out_data  (out_beat_t)
//   cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// A text beat is registered, evaluated in the next cycle and its result
// bytes are sent one per cycle from the bundle register while out_ready is high.
// A beat with no result bytes never waits on the output; one with bytes
// waits for the bundle register, and the next beat can enter while it sends.
// Reset is asynchronous and clears all line state; no clearing pass.
// Output stalls propagate back to in_ready in the same cycle.
// ----------------------------------------------------------------------------
module assembler_source_tokenizer_top
	import srctok_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data
);

	cfg_t    cfg;
	bundle_t bundle;
	logic    push;
	logic    push_ready;

	srctok_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	srctok_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_ready (push_ready),
		.bundle     (bundle)
	);

	srctok_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.bundle     (bundle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
